[src/isc_pkg.sv]
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types for the interval set coalescer: cell operations and the
// per-cell status flags seen by the neighbours and the control.
// ----------------------------------------------------------------------------
package isc_pkg;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_MERGE,
    OP_JNEXT,
    OP_JPREV,
    OP_INSERT,
    OP_ROTATE
  } cell_op_e;

  typedef struct packed {
    logic valid;
    logic le;
    logic cov;
    logic jp;
    logic jn;
  } cell_stat_t;

endpackage

[src/interval_set_coalescer_top.sv]
// ----------------------------------------------------------------------------
// interval_set_coalescer_top
// Sorted table of disjoint, non-adjacent ranges built as a row of cells.
// ----------------------------------------------------------------------------
// An add beat runs through a compare step and an update step: the cells
// compare the value against their ranges in parallel in the compare step, and
// in the update step the table is extended, merged by a left shift of the row,
// or grown by a right shift, and the one result beat is loaded; the next beat
// is taken in that update step while the output is free. A dump rotates the
// row one cell per cycle and puts out one range beat each cycle while the
// output is free, ascending (a single empty beat for an empty table), and then
// returns to idle before the next beat is taken. A stalled result holds the
// row and the input. Capacity is CAPACITY ranges; an add that needs a new entry
// in a full table is dropped with a full status.
module interval_set_coalescer_top #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] range_low_o,
  output logic [15:0] range_high_o,
  output logic        is_last_o
);
  import isc_pkg::*;

  localparam int WB = (VALUE_BITS > 16) ? VALUE_BITS : 16;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_COVERED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD, S_DUMP} state_e;

  state_e                state_q, state_d;
  logic                  out_valid_q;
  logic [2:0]            status_q;
  logic [15:0]           low_q, high_q;
  logic                  last_q;
  logic [CW-1:0]         count_q, count_d, left_q;
  logic [VALUE_BITS-1:0] v_q;

  logic [WB-1:0]         wide_in, wide_lo, wide_hi;
  logic [VALUE_BITS-1:0] val;

  cell_stat_t            stat  [CAPACITY];
  cell_stat_t            lstat [CAPACITY];
  cell_stat_t            rstat [CAPACITY];
  logic [VALUE_BITS-1:0] cstart[CAPACITY];
  logic [VALUE_BITS-1:0] cend  [CAPACITY];
  logic [VALUE_BITS-1:0] lstart[CAPACITY];
  logic [VALUE_BITS-1:0] lend  [CAPACITY];
  logic [VALUE_BITS-1:0] rstart[CAPACITY];
  logic [VALUE_BITS-1:0] rend  [CAPACITY];
  logic [CAPACITY-1:0]   valid_vec;

  logic                  any_cov, any_jp, any_jn, full;
  logic                  out_free, in_acc, load_out;
  cell_op_e              cell_op, dec_op;
  logic [2:0]            dec_status;
  logic [CW-1:0]         dec_count;

  assign wide_in = WB'(value_i);
  assign val     = wide_in[VALUE_BITS-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_left_edge
      assign lstat[i]  = cell_stat_t'{valid: 1'b0, le: 1'b1, cov: 1'b0, jp: 1'b0, jn: 1'b0};
      assign lstart[i] = '0;
      assign lend[i]   = '0;
    end else begin : g_left
      assign lstat[i]  = stat[i-1];
      assign lstart[i] = cstart[i-1];
      assign lend[i]   = cend[i-1];
    end
    if (i == CAPACITY - 1) begin : g_right_edge
      assign rstat[i]  = '0;
      assign rstart[i] = '0;
      assign rend[i]   = '0;
    end else begin : g_right
      assign rstat[i]  = stat[i+1];
      assign rstart[i] = cstart[i+1];
      assign rend[i]   = cend[i+1];
    end

    isc_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (cell_op),
      .value_i      (v_q),
      .left_stat_i  (lstat[i]),
      .left_start_i (lstart[i]),
      .left_end_i   (lend[i]),
      .right_stat_i (rstat[i]),
      .right_start_i(rstart[i]),
      .right_end_i  (rend[i]),
      .head_start_i (cstart[0]),
      .head_end_i   (cend[0]),
      .stat_o       (stat[i]),
      .start_o      (cstart[i]),
      .end_o        (cend[i])
    );

    assign valid_vec[i] = stat[i].valid;
  end

  always_comb begin
    any_cov = 1'b0;
    any_jp  = 1'b0;
    any_jn  = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_cov = any_cov | stat[i].cov;
      any_jp  = any_jp | stat[i].jp;
      any_jn  = any_jn | stat[i].jn;
    end
  end

  assign full = stat[CAPACITY-1].valid;

  always_comb begin
    dec_op     = OP_HOLD;
    dec_status = ST_ADDED;
    dec_count  = count_q;
    if (any_cov) begin
      dec_status = ST_COVERED;
    end else if (any_jp && any_jn) begin
      dec_op    = OP_MERGE;
      dec_count = count_q - CW'(1);
    end else if (any_jn) begin
      dec_op = OP_JNEXT;
    end else if (any_jp) begin
      dec_op = OP_JPREV;
    end else if (full) begin
      dec_status = ST_FULL;
    end else begin
      dec_op    = OP_INSERT;
      dec_count = count_q + CW'(1);
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_UPD) && out_free);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_out   = ((state_q == S_UPD) || (state_q == S_DUMP)) && out_free;

  always_comb begin
    cell_op = OP_HOLD;
    count_d = count_q;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = kind_i ? S_DUMP : S_CMP;
      end
      S_CMP: begin
        cell_op = OP_CMP;
        state_d = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          cell_op = dec_op;
          count_d = dec_count;
          if (in_acc) state_d = kind_i ? S_DUMP : S_CMP;
          else        state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          if (left_q != '0) cell_op = OP_ROTATE;
          if (left_q <= CW'(1)) state_d = S_IDLE;
        end
      end
      default: ;
    endcase
  end

  assign wide_lo = WB'(cstart[0]);
  assign wide_hi = WB'(cend[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      left_q      <= '0;
      status_q    <= ST_ADDED;
      low_q       <= '0;
      high_q      <= '0;
      last_q      <= 1'b0;
      v_q         <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (in_acc) begin
        v_q    <= val;
        left_q <= count_d;
      end else if ((state_q == S_DUMP) && out_free && (left_q != '0)) begin
        left_q <= left_q - CW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        if (state_q == S_UPD) begin
          status_q <= dec_status;
          low_q    <= '0;
          high_q   <= '0;
          last_q   <= 1'b1;
        end else if (left_q == '0) begin
          status_q <= ST_EMPTY;
          low_q    <= '0;
          high_q   <= '0;
          last_q   <= 1'b1;
        end else begin
          status_q <= ST_RANGE;
          low_q    <= wide_lo[15:0];
          high_q   <= wide_hi[15:0];
          last_q   <= (left_q == CW'(1));
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign range_low_o  = low_q;
  assign range_high_o = high_q;
  assign is_last_o    = last_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == count_q)
    else $error("range count differs from occupied cells");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + CAPACITY'(1))) == '0)
    else $error("occupied cells do not form a prefix");

  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EMPTY)) |-> (count_q == '0))
    else $error("empty beat while table holds ranges");

endmodule

[src/isc_cell.sv]
// ----------------------------------------------------------------------------
// isc_cell
// One entry of the range table. Holds one range, compares it against the
// broadcast value, and shifts or rotates with its neighbours on command.
// ----------------------------------------------------------------------------
module isc_cell #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  isc_pkg::cell_op_e     op_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  isc_pkg::cell_stat_t   left_stat_i,
  input  logic [VALUE_BITS-1:0] left_start_i,
  input  logic [VALUE_BITS-1:0] left_end_i,
  input  isc_pkg::cell_stat_t   right_stat_i,
  input  logic [VALUE_BITS-1:0] right_start_i,
  input  logic [VALUE_BITS-1:0] right_end_i,
  input  logic [VALUE_BITS-1:0] head_start_i,
  input  logic [VALUE_BITS-1:0] head_end_i,
  output isc_pkg::cell_stat_t   stat_o,
  output logic [VALUE_BITS-1:0] start_o,
  output logic [VALUE_BITS-1:0] end_o
);
  import isc_pkg::*;

  logic                  valid_q, valid_d;
  logic [VALUE_BITS-1:0] start_q, start_d;
  logic [VALUE_BITS-1:0] end_q, end_d;
  logic                  le_q, cov_q, ea_q, sa_q;
  logic                  is_prev, is_pos, after_pos;
  logic [VALUE_BITS:0]   v_inc, end_inc;

  assign is_prev   = le_q && !right_stat_i.le;
  assign is_pos    = !le_q && left_stat_i.le;
  assign after_pos = !le_q && !left_stat_i.le;
  assign v_inc     = {1'b0, value_i} + {{VALUE_BITS{1'b0}}, 1'b1};
  assign end_inc   = {1'b0, end_q} + {{VALUE_BITS{1'b0}}, 1'b1};

  always_comb begin
    valid_d = valid_q;
    start_d = start_q;
    end_d   = end_q;
    case (op_i)
      OP_MERGE: begin
        if (is_prev) begin
          end_d = right_end_i;
        end else if (!le_q) begin
          valid_d = right_stat_i.valid;
          start_d = right_start_i;
          end_d   = right_end_i;
        end
      end
      OP_JNEXT: begin
        if (is_pos) start_d = value_i;
      end
      OP_JPREV: begin
        if (is_prev) end_d = value_i;
      end
      OP_INSERT: begin
        if (is_pos) begin
          valid_d = 1'b1;
          start_d = value_i;
          end_d   = value_i;
        end else if (after_pos) begin
          valid_d = left_stat_i.valid;
          start_d = left_start_i;
          end_d   = left_end_i;
        end
      end
      OP_ROTATE: begin
        if (valid_q) begin
          if (right_stat_i.valid) begin
            start_d = right_start_i;
            end_d   = right_end_i;
          end else begin
            start_d = head_start_i;
            end_d   = head_end_i;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      le_q    <= 1'b0;
      cov_q   <= 1'b0;
      ea_q    <= 1'b0;
      sa_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (op_i == OP_CMP) begin
        le_q  <= valid_q && (start_q <= value_i);
        cov_q <= valid_q && (value_i <= end_q);
        ea_q  <= valid_q && (end_inc == {1'b0, value_i});
        sa_q  <= valid_q && ({1'b0, start_q} == v_inc);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
  end

  assign stat_o.valid = valid_q;
  assign stat_o.le    = le_q;
  assign stat_o.cov   = is_prev && cov_q;
  assign stat_o.jp    = is_prev && ea_q;
  assign stat_o.jn    = is_pos && sa_q;
  assign start_o      = start_q;
  assign end_o        = end_q;

endmodule

[test/isc_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_tb_pkg
// Codes shared by the coalescer testbench: the item kinds on the input
// channel and the status values on the result channel.
// ----------------------------------------------------------------------------
package isc_tb_pkg;

  typedef enum logic {
    KIND_ADD,
    KIND_DUMP
  } isc_kind_e;

  typedef enum logic [2:0] {
    ST_ADDED,
    ST_COVERED,
    ST_FULL,
    ST_RANGE,
    ST_EMPTY
  } isc_status_e;

  typedef struct packed {
    isc_status_e status;
    logic [15:0] lo;
    logic [15:0] hi;
    logic        is_last;
  } range_beat_t;

endpackage

[test/isc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_checker
// Watches both channels of the interval set coalescer. Every accepted input
// beat is run through a local copy of the range table, which queues the
// result beats it must cause; every accepted result beat is compared field
// by field with the oldest queued one. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module isc_checker
  import isc_tb_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        kind_i,
  input  logic [15:0] value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] range_low_i,
  input  logic [15:0] range_high_i,
  input  logic        is_last_i,
  output int          pending_o,
  output int          fails_o
);

  localparam logic [15:0] VMASK =
    (VALUE_BITS >= 16) ? 16'hFFFF : 16'((1 << VALUE_BITS) - 1);

  logic [15:0] run_lo [CAPACITY];
  logic [15:0] run_hi [CAPACITY];
  int          run_count;
  range_beat_t beat_q [$];

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fails_o++;
  endtask

  task automatic push_beat(input isc_status_e st, input logic [15:0] lo,
                           input logic [15:0] hi, input logic is_last);
    range_beat_t b;
    b.status  = st;
    b.lo      = lo;
    b.hi      = hi;
    b.is_last = is_last;
    beat_q.insert(beat_q.size(), b);
  endtask

  task automatic predict_add(input logic [15:0] raw);
    logic [15:0] v;
    int          pos;
    logic        jprev;
    logic        jnext;
    isc_status_e st;
    v     = raw & VMASK;
    pos   = 0;
    jprev = 1'b0;
    jnext = 1'b0;
    while (pos < run_count && run_lo[pos] <= v) pos++;
    if (pos > 0 && v <= run_hi[(pos > 0) ? pos - 1 : 0]) begin
      st = ST_COVERED;
    end else begin
      // no wrap at either end of the value range
      if (pos > 0) jprev = ({1'b0, run_hi[pos-1]} + 17'd1) == {1'b0, v};
      if (pos < run_count) jnext = {1'b0, run_lo[pos]} == ({1'b0, v} + 17'd1);
      st = ST_ADDED;
      if (jprev && jnext) begin
        run_hi[pos-1] = run_hi[pos];
        for (int i = pos; i + 1 < run_count; i++) begin
          run_lo[i] = run_lo[i+1];
          run_hi[i] = run_hi[i+1];
        end
        run_count--;
      end else if (jnext) begin
        run_lo[pos] = v;
      end else if (jprev) begin
        run_hi[pos-1] = v;
      end else if (run_count >= CAPACITY) begin
        st = ST_FULL;
      end else begin
        for (int i = run_count; i > pos; i--) begin
          run_lo[i] = run_lo[i-1];
          run_hi[i] = run_hi[i-1];
        end
        run_lo[pos] = v;
        run_hi[pos] = v;
        run_count++;
      end
    end
    push_beat(st, 16'd0, 16'd0, 1'b1);
  endtask

  task automatic predict_dump();
    if (run_count == 0) begin
      push_beat(ST_EMPTY, 16'd0, 16'd0, 1'b1);
    end else begin
      for (int i = 0; i < run_count; i++)
        push_beat(ST_RANGE, run_lo[i], run_hi[i], i == run_count - 1);
    end
  endtask

  task automatic check_beat();
    range_beat_t want;
    if (beat_q.size() == 0) begin
      report_mismatch($sformatf("result beat with none due, status %0d", status_i));
    end else begin
      want = beat_q.pop_front();
      if (status_i !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status_i, want.status));
      if (range_low_i !== want.lo)
        report_mismatch($sformatf("range_low %0h, want %0h", range_low_i, want.lo));
      if (range_high_i !== want.hi)
        report_mismatch($sformatf("range_high %0h, want %0h", range_high_i, want.hi));
      if (is_last_i !== want.is_last)
        report_mismatch($sformatf("is_last %0b, want %0b", is_last_i, want.is_last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_count = 0;
      beat_q.delete();
      pending_o = 0;
      fails_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (kind_i == KIND_DUMP) predict_dump();
        else predict_add(value_i);
      end
      if (out_valid_i && out_ready_i) check_beat();
      pending_o = beat_q.size();
    end
  end

endmodule

[test/tb_interval_set_coalescer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_set_coalescer_top
// Drives add and dump beats into the interval set coalescer with random gaps
// on the input and random stalls on the output. A directed run covers the
// empty table, both ends of the value range, extension, merging, a full
// table and full dumps; random beats then cluster around earlier values so
// that ranges keep growing, merging and filling the table.
// ----------------------------------------------------------------------------
module tb_interval_set_coalescer_top;
  import isc_tb_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic [15:0] value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [15:0] range_low_o;
  logic [15:0] range_high_o;
  logic        is_last_o;

  int          pending;
  int          fails;
  logic        idle_on;
  int          hold_left;
  logic [15:0] sent_q [$];

  interval_set_coalescer_top #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .range_low_o  (range_low_o),
    .range_high_o (range_high_o),
    .is_last_o    (is_last_o)
  );

  isc_checker #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status_o),
    .range_low_i  (range_low_o),
    .range_high_i (range_high_o),
    .is_last_i    (is_last_o),
    .pending_o    (pending),
    .fails_o      (fails)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // output stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) hold_left <= pick_gap();
    end
  end

  task automatic send_beat(input isc_kind_e k, input logic [15:0] v);
    int g;
    g = idle_on ? pick_gap() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    value_i    <= v;
    if (k == KIND_ADD) sent_q.insert(sent_q.size(), v);
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] near_value();
    logic [15:0] h;
    int          n;
    h = sent_q[$urandom_range(0, sent_q.size() - 1)];
    n = int'(h) + $urandom_range(0, 4) - 2;
    if (n < 0 || n > 65535) return h;
    return 16'(n);
  endfunction

  initial begin
    int          r;
    logic [15:0] base;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    kind_i     = 1'b0;
    value_i    = 16'd0;
    idle_on    = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, value edges, extension, merging
    send_beat(KIND_DUMP, 16'hFFFF);
    send_beat(KIND_ADD, 16'h0000);
    send_beat(KIND_ADD, 16'hFFFF);
    send_beat(KIND_ADD, 16'hFFFE);
    send_beat(KIND_ADD, 16'h0001);
    send_beat(KIND_ADD, 16'h0000);
    send_beat(KIND_ADD, 16'h0005);
    send_beat(KIND_ADD, 16'h0003);
    send_beat(KIND_ADD, 16'h0004);
    send_beat(KIND_ADD, 16'h0002);
    // fill the table, then full drop, extension when full, full dump
    for (int i = 0; i < 14; i++) send_beat(KIND_ADD, 16'h4000 + 16'(2 * i));
    send_beat(KIND_ADD, 16'h8000);
    send_beat(KIND_ADD, 16'h401B);
    send_beat(KIND_DUMP, 16'h0000);

    wait_drained();

    base = 16'($urandom);
    for (int n = 0; n < 132; n++) begin
      if (n % 40 == 0) base = 16'($urandom_range(0, 65535 - 64));
      if (n == 40) idle_on <= 1'b0;
      if (n == 80) idle_on <= 1'b1;
      if (n == 80 || n == 120) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 10) send_beat(KIND_DUMP, 16'($urandom));
      else if (r < 55) send_beat(KIND_ADD, near_value());
      else if (r < 80) send_beat(KIND_ADD, base + 16'($urandom_range(0, 63)));
      else send_beat(KIND_ADD, 16'($urandom));
    end
    send_beat(KIND_DUMP, 16'h0000);
    in_valid_i <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
